>>> design/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, constants and decode helpers of the command packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

	localparam int NUM_KINDS     = 8;
	localparam int PAYLOAD_DEPTH = 21;
	localparam int CODE_W        = 8;
	localparam int CFG_IDX_W     = 4;
	localparam int COUNT_W       = 5;
	localparam int KIND_W        = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_CONTROL     = 3'd0,
		KIND_ESTOP       = 3'd1,
		KIND_ESTOP_CLEAR = 3'd2,
		KIND_DISCOVER    = 3'd3,
		KIND_CONFIRM     = 3'd4,
		KIND_START_SEQ   = 3'd5,
		KIND_SET_SETTING = 3'd6,
		KIND_GET_SETTING = 3'd7
	} kind_t;

	// bytes after the type byte, entry 0 is the robot id
	typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} match_t;

	typedef struct packed {
		logic  fire;
		kind_t kind;
	} done_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  target_id;
		logic [7:0]  drive_mode;
		logic [15:0] vel_x;
		logic [15:0] vel_y;
		logic [15:0] turn_rate;
		logic [7:0]  step_number;
		logic        approved;
		logic [7:0]  sequence_number;
		logic [31:0] setting_value;
		logic [63:0] key_low;
		logic [63:0] key_high;
	} result_t;

	// packet length including the type byte
	function automatic logic [COUNT_W-1:0] pkt_len(kind_t k);
		logic [COUNT_W-1:0] len;
		case (k)
			KIND_CONTROL:     len = 5'd9;
			KIND_ESTOP:       len = 5'd2;
			KIND_ESTOP_CLEAR: len = 5'd2;
			KIND_DISCOVER:    len = 5'd2;
			KIND_CONFIRM:     len = 5'd4;
			KIND_START_SEQ:   len = 5'd3;
			KIND_SET_SETTING: len = 5'd22;
			KIND_GET_SETTING: len = 5'd18;
			default:          len = 5'd2;
		endcase
		return len;
	endfunction

endpackage

>>> design/cpd_match.sv
// ----------------------------------------------------------------------------
// cpd_match
// Type code registers and the priority match of an idle byte against them.
// ----------------------------------------------------------------------------
module cpd_match import cpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data,
	input  logic [7:0]           rx_byte,
	output match_t               match
);

	logic [NUM_KINDS-1:0][CODE_W-1:0] codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KINDS; i++) begin
				codes_q[i] <= CODE_W'(i + 1);
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_KINDS))) begin
			codes_q[cfg_index[KIND_W-1:0]] <= cfg_data;
		end
	end

	// walk from the last kind down so the earliest match wins
	always_comb begin
		match.hit  = 1'b0;
		match.kind = KIND_CONTROL;
		for (int k = NUM_KINDS - 1; k >= 0; k--) begin
			if (codes_q[k] == rx_byte) begin
				match.hit  = 1'b1;
				match.kind = kind_t'(KIND_W'(k));
			end
		end
	end

endmodule

>>> design/cpd_collect.sv
// ----------------------------------------------------------------------------
// cpd_collect
// Packet state and payload store; flags the word that completes a packet.
// ----------------------------------------------------------------------------
module cpd_collect import cpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_vld,
	input  logic [7:0] rx_byte,
	input  match_t   match,
	output done_t    done,
	output payload_t pay_view
);

	logic               in_packet_q;
	kind_t              kind_q;
	logic [COUNT_W-1:0] count_q;
	payload_t           pay_q;
	logic               last;
	logic [COUNT_W-1:0] count_inc;

	assign count_inc = count_q + COUNT_W'(1);
	assign last      = count_inc >= pkt_len(kind_q);

	assign done.fire = byte_vld && in_packet_q && last;
	assign done.kind = kind_q;

	// store as it will look with the current word written
	always_comb begin
		pay_view = pay_q;
		for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
			if (in_packet_q && count_q == COUNT_W'(i + 1)) begin
				pay_view[i] = rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			kind_q      <= KIND_CONTROL;
			count_q     <= '0;
		end else if (byte_vld) begin
			if (!in_packet_q) begin
				if (match.hit) begin
					in_packet_q <= 1'b1;
					kind_q      <= match.kind;
					count_q     <= COUNT_W'(1);
				end
			end else if (last) begin
				in_packet_q <= 1'b0;
				kind_q      <= KIND_CONTROL;
				count_q     <= '0;
			end else begin
				count_q <= count_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_vld) begin
			pay_q <= pay_view;
		end
	end

endmodule

>>> design/cpd_result.sv
// ----------------------------------------------------------------------------
// cpd_result
// Field decode of a finished packet and the command output register.
// ----------------------------------------------------------------------------
module cpd_result import cpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  done_t    done,
	input  payload_t pay_view,
	input  logic     cmd_ready,
	output logic     cmd_valid,
	output result_t  res
);

	logic    cmd_valid_q;
	result_t res_q;
	result_t res_d;

	always_comb begin
		res_d           = '0;
		res_d.kind      = done.kind;
		res_d.target_id = pay_view[0];
		case (done.kind)
			KIND_CONTROL: begin
				res_d.drive_mode = pay_view[1];
				res_d.vel_x      = {pay_view[3], pay_view[2]};
				res_d.vel_y      = {pay_view[5], pay_view[4]};
				res_d.turn_rate  = {pay_view[7], pay_view[6]};
			end
			KIND_CONFIRM: begin
				res_d.step_number = pay_view[1];
				res_d.approved    = pay_view[2] != 8'd0;
			end
			KIND_START_SEQ: begin
				res_d.sequence_number = pay_view[1];
			end
			KIND_SET_SETTING: begin
				res_d.setting_value = {pay_view[20], pay_view[19], pay_view[18], pay_view[17]};
				res_d.key_low       = pay_view[8:1];
				res_d.key_high      = pay_view[16:9];
			end
			KIND_GET_SETTING: begin
				res_d.key_low  = pay_view[8:1];
				res_d.key_high = pay_view[16:9];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (done.fire) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.fire) begin
			res_q <= res_d;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign res       = res_q;

endmodule

>>> design/command_packet_deframer.sv
// ----------------------------------------------------------------------------
// command_packet_deframer
// Byte stream deframer: finds typed command packets and emits one decoded
// command word per completed packet.
// ----------------------------------------------------------------------------
// the command register is written when its last byte moves out of the input register
// throughput: one byte per cycle while no finished command waits; the input
//   register feeds the packet logic, which writes the command register
// bytes stall only while a finished command waits and the input register is full
// reset: type codes back to 1..8, no packet open, no command pending
module command_packet_deframer import cpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output logic [KIND_W-1:0]    kind,
	output logic [7:0]           target_id,
	output logic [7:0]           drive_mode,
	output logic [15:0]          vel_x,
	output logic [15:0]          vel_y,
	output logic [15:0]          turn_rate,
	output logic [7:0]           step_number,
	output logic                 approved,
	output logic [7:0]           sequence_number,
	output logic [31:0]          setting_value,
	output logic [63:0]          key_low,
	output logic [63:0]          key_high
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;
	match_t     match;
	done_t      done;
	payload_t   pay_view;
	result_t    res;

	// a word moves on unless a command is stuck in the output register
	assign advance  = valid_s1 && (!cmd_valid || cmd_ready);
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	cpd_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (rx_byte_s1),
		.match     (match)
	);

	cpd_collect u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (advance),
		.rx_byte  (rx_byte_s1),
		.match    (match),
		.done     (done),
		.pay_view (pay_view)
	);

	cpd_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.done      (done),
		.pay_view  (pay_view),
		.cmd_ready (cmd_ready),
		.cmd_valid (cmd_valid),
		.res       (res)
	);

	assign kind            = res.kind;
	assign target_id       = res.target_id;
	assign drive_mode      = res.drive_mode;
	assign vel_x           = res.vel_x;
	assign vel_y           = res.vel_y;
	assign turn_rate       = res.turn_rate;
	assign step_number     = res.step_number;
	assign approved        = res.approved;
	assign sequence_number = res.sequence_number;
	assign setting_value   = res.setting_value;
	assign key_low         = res.key_low;
	assign key_high        = res.key_high;

endmodule

>>> design/cpd_checker.sv
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks of the command packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cpd_checker import cpd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rx_ready,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [KIND_W-1:0] kind,
	input logic [7:0]        target_id,
	input logic [7:0]        drive_mode,
	input logic [15:0]       vel_x,
	input logic [15:0]       turn_rate,
	input logic [31:0]       setting_value,
	input logic [63:0]       key_low,
	input logic [63:0]       key_high
);

	// a held command keeps its kind and target id
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(kind) && $stable(target_id))
		else $error("command word changed while stalled");

	// input only backs up behind a stalled command
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> cmd_valid && !cmd_ready)
		else $error("input stalled without a pending command");

	// control fields are zero on other kinds
	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && kind != KIND_CONTROL |-> drive_mode == 8'd0 && vel_x == 16'd0
			&& turn_rate == 16'd0)
		else $error("control fields set on a non-control command");

	// key and setting only on set and get
	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && kind != KIND_SET_SETTING && kind != KIND_GET_SETTING
			|-> key_low == 64'd0 && key_high == 64'd0 && setting_value == 32'd0)
		else $error("key fields set on a command without a key");

	// reset seen at an edge leaves no command pending at the next one
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !cmd_valid)
		else $error("command pending after reset");

endmodule

bind command_packet_deframer cpd_checker u_cpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_ready      (rx_ready),
	.cmd_valid     (cmd_valid),
	.cmd_ready     (cmd_ready),
	.kind          (kind),
	.target_id     (target_id),
	.drive_mode    (drive_mode),
	.vel_x         (vel_x),
	.turn_rate     (turn_rate),
	.setting_value (setting_value),
	.key_low       (key_low),
	.key_high      (key_high)
);
